@@ hw/rtl/rbs_pkg.sv @@
`default_nettype none

package rbs_pkg;

   // widest store address over the whole MAX_CELLS range
   localparam int CELL_AW_MAX = 20;

   localparam int QUEUE_DEPTH    = 8;
   localparam int RESULT_DEPTH   = 8;
   localparam int FRAC_THRESHOLD = 6553;
   localparam int Q_ONE          = 65536;

   localparam logic [2:0] CSR_X_ORIGIN    = 3'd0;
   localparam logic [2:0] CSR_Y_TOP       = 3'd1;
   localparam logic [2:0] CSR_X_SCALE     = 3'd2;
   localparam logic [2:0] CSR_Y_SCALE     = 3'd3;
   localparam logic [2:0] CSR_COLUMNS     = 3'd4;
   localparam logic [2:0] CSR_ROWS        = 3'd5;
   localparam logic [2:0] CSR_FLOOR_VALUE = 3'd6;

   typedef enum logic [2:0] {
      KIND_WRITE,
      KIND_DROP,
      KIND_OUTSIDE,
      KIND_CELL,
      KIND_BLEND
   } kind_type;

   typedef struct packed {
      logic signed [31:0] x_origin;
      logic signed [31:0] y_top;
      logic [31:0]        x_scale;
      logic [31:0]        y_scale;
      logic [10:0]        columns;
      logic [10:0]        rows;
      logic signed [31:0] floor_value;
   } cfg_type;

   typedef struct packed {
      kind_type               kind;
      logic [CELL_AW_MAX-1:0] addr1;
      logic [CELL_AW_MAX-1:0] addr2;
      logic [CELL_AW_MAX-1:0] addr3;
      logic [CELL_AW_MAX-1:0] addr4;
      logic signed [16:0]     dx;
      logic signed [16:0]     dy;
      logic signed [31:0]     value;
   } cmd_type;

endpackage

`default_nettype wire

@@ hw/rtl/rbs_if.sv @@
`default_nettype none

interface rbs_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [31:0] x_pos;
   logic signed [31:0] y_pos;
   logic [15:0]        cell_index;
   logic signed [31:0] cell_value;

   modport source (output valid, op, x_pos, y_pos, cell_index, cell_value, input ready);
   modport sink (input valid, op, x_pos, y_pos, cell_index, cell_value, output ready);
endinterface

interface rbs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample_value;
   logic               outside;

   modport source (output valid, sample_value, outside, input ready);
   modport sink (input valid, sample_value, outside, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/raster_bilinear_sampler.sv @@
`default_nettype none

// A sample request passes through the front pipeline, the command queue, the store
// read and the blend pipeline into the result buffer; a write lands in the raster
// store and gives no result.
// Throughput: one write or plain sample per cycle while the queue and result buffer
// have room; a blend makes four neighbour reads through the single store read port.
// Synchronous active-high reset restores register defaults and empties the queues only.
module raster_bilinear_sampler
   import rbs_pkg::*;
#(
   parameter int MAX_CELLS = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   rbs_req_if.sink          req_chan,
   rbs_rsp_if.source        rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    q_push, q_pop, q_empty, q_full;
   cmd_type q_din, q_dout;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_X_ORIGIN:    cfg_in.x_origin    = csr_wdata;
            CSR_Y_TOP:       cfg_in.y_top       = csr_wdata;
            CSR_X_SCALE:     cfg_in.x_scale     = csr_wdata;
            CSR_Y_SCALE:     cfg_in.y_scale     = csr_wdata;
            CSR_COLUMNS:     cfg_in.columns     = csr_wdata[10:0];
            CSR_ROWS:        cfg_in.rows        = csr_wdata[10:0];
            CSR_FLOOR_VALUE: cfg_in.floor_value = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_origin    <= 32'sd0;
         cfg_ff.y_top       <= 32'sd0;
         cfg_ff.x_scale     <= 32'h0001_0000;
         cfg_ff.y_scale     <= 32'h0001_0000;
         cfg_ff.columns     <= 11'd256;
         cfg_ff.rows        <= 11'd256;
         cfg_ff.floor_value <= 32'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rbs_front #(
      .MAX_CELLS (MAX_CELLS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .q_pop    (q_pop),
      .q_push   (q_push),
      .q_data   (q_din)
   );

   rbs_fifo #(
      .DEPTH      (QUEUE_DEPTH),
      .entry_type (cmd_type)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty),
      .full  (q_full)
   );

   rbs_back #(
      .MAX_CELLS (MAX_CELLS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .floor_value (cfg_ff.floor_value),
      .q_empty     (q_empty),
      .q_data      (q_dout),
      .q_pop       (q_pop),
      .rsp_chan    (rsp_chan)
   );

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("top: request pushed into a full queue");

endmodule

`default_nettype wire

@@ hw/rtl/rbs_fifo.sv @@
`default_nettype none

module rbs_fifo #(
   parameter int DEPTH = 8,
   parameter type entry_type = logic
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type din,
   input  wire logic      pop,
   output entry_type      dout,
   output logic           empty,
   output logic           full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type        entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_pop;

   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CW'(DEPTH));
   assign dout   = entries_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/rbs_front.sv @@
`default_nettype none

module rbs_front
   import rbs_pkg::*;
#(
   parameter int MAX_CELLS = 65536
) (
   input  wire logic    clock,
   input  wire logic    reset,
   rbs_req_if.sink      req_chan,
   input  wire cfg_type cfg,
   input  wire logic    q_pop,
   output logic         q_push,
   output cmd_type      q_data
);

   localparam int AW    = $clog2(MAX_CELLS);
   localparam int NW    = (AW + 12 > 22) ? AW + 12 : 22;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // requests in the pipeline plus those waiting in the queue
   logic [CNT_W-1:0]   used_ff, used_in;
   logic               accept;
   logic [21:0]        col_row;
   logic [21:0]        cells_ff, cells_in;

   // stage 1: offsets from the origin, split into sign and magnitude
   logic signed [32:0] diff_x, diff_y;
   logic [31:0]        mag_x_in, mag_y_in;
   logic               s1_valid_ff, s1_op_ff, s1_neg_x_ff, s1_neg_y_ff;
   logic [31:0]        s1_mag_x_ff, s1_mag_y_ff;
   logic [15:0]        s1_index_ff;
   logic signed [31:0] s1_value_ff;

   // stage 2: scale products
   logic [63:0]        prod_x_in, prod_y_in;
   logic               s2_valid_ff, s2_op_ff, s2_neg_x_ff, s2_neg_y_ff;
   logic [63:0]        s2_prod_x_ff, s2_prod_y_ff;
   logic [15:0]        s2_index_ff;
   logic signed [31:0] s2_value_ff;

   // stage 3: signed pixel position, row offset
   logic [32:0]        ip_x, ip_y;
   logic [16:0]        fr_x, fr_y;
   logic signed [32:0] jx_in, jy_in;
   logic signed [16:0] dx_in, dy_in;
   logic signed [44:0] jyc_in;
   logic               s3_valid_ff, s3_op_ff;
   logic signed [32:0] s3_jx_ff;
   logic signed [44:0] s3_jyc_ff;
   logic signed [16:0] s3_dx_ff, s3_dy_ff;
   logic [15:0]        s3_index_ff;
   logic signed [31:0] s3_value_ff;

   // stage 4: flat index and classification
   logic signed [45:0] j1_in;
   logic               outside_in, blend_in, index_ok;
   logic [CELL_AW_MAX+15:0] index_wide;
   kind_type           kind_in;
   logic [AW-1:0]      addr_in;
   logic               s4_valid_ff;
   kind_type           s4_kind_ff;
   logic [AW-1:0]      s4_addr_ff;
   logic signed [16:0] s4_dx_ff, s4_dy_ff;
   logic signed [31:0] s4_value_ff;

   // neighbours, clamped against the last cell
   logic [NW-1:0]      j1_n, mxr, col_n, j2, j3, j4, c2, c3, c4;

   assign req_chan.ready = (used_ff < CNT_W'(QUEUE_DEPTH));
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      used_in = used_ff;
      if (accept && !q_pop) begin
         used_in = used_ff + 1'b1;
      end else if (!accept && q_pop) begin
         used_in = used_ff - 1'b1;
      end
   end

   assign col_row  = cfg.columns * cfg.rows;
   assign cells_in = (col_row > 22'(MAX_CELLS)) ? 22'(MAX_CELLS) : col_row;

   assign diff_x   = {req_chan.x_pos[31], req_chan.x_pos} - {cfg.x_origin[31], cfg.x_origin};
   assign diff_y   = {cfg.y_top[31], cfg.y_top} - {req_chan.y_pos[31], req_chan.y_pos};
   assign mag_x_in = diff_x[32] ? 32'(33'd0 - diff_x) : diff_x[31:0];
   assign mag_y_in = diff_y[32] ? 32'(33'd0 - diff_y) : diff_y[31:0];

   assign prod_x_in = s1_mag_x_ff * cfg.x_scale;
   assign prod_y_in = s1_mag_y_ff * cfg.y_scale;

   always_comb begin
      ip_x   = {1'b0, s2_prod_x_ff[63:32]};
      ip_y   = {1'b0, s2_prod_y_ff[63:32]};
      fr_x   = {1'b0, s2_prod_x_ff[31:16]};
      fr_y   = {1'b0, s2_prod_y_ff[31:16]};
      jx_in  = s2_neg_x_ff ? 33'd0 - ip_x : ip_x;
      jy_in  = s2_neg_y_ff ? 33'd0 - ip_y : ip_y;
      dx_in  = s2_neg_x_ff ? 17'd0 - fr_x : fr_x;
      dy_in  = s2_neg_y_ff ? 17'd0 - fr_y : fr_y;
      jyc_in = jy_in * $signed({1'b0, cfg.columns});
   end

   always_comb begin
      j1_in      = 46'(s3_jyc_ff) + 46'(s3_jx_ff);
      outside_in = j1_in[45] || (j1_in[44:0] >= 45'(cells_ff));
      blend_in   = (s3_dx_ff > $signed(17'(FRAC_THRESHOLD)))
                || (s3_dy_ff > $signed(17'(FRAC_THRESHOLD)));
      index_wide = {{CELL_AW_MAX{1'b0}}, s3_index_ff};
      index_ok   = (32'(s3_index_ff) < 32'(MAX_CELLS));
      if (!s3_op_ff) begin
         kind_in = index_ok ? KIND_WRITE : KIND_DROP;
         addr_in = index_wide[AW-1:0];
      end else begin
         addr_in = j1_in[AW-1:0];
         if (outside_in) begin
            kind_in = KIND_OUTSIDE;
         end else if (blend_in) begin
            kind_in = KIND_BLEND;
         end else begin
            kind_in = KIND_CELL;
         end
      end
   end

   always_comb begin
      j1_n  = NW'(s4_addr_ff);
      mxr   = NW'(cells_ff) - 1'b1;
      col_n = NW'(cfg.columns);
      j2    = j1_n + 1'b1;
      c2    = (j2 > mxr) ? j1_n : j2;
      j3    = j1_n + col_n;
      c3    = (j3 > mxr) ? c2 : j3;
      j4    = j3 + 1'b1;
      c4    = (j4 > mxr) ? c3 : j4;
   end

   always_comb begin
      q_push       = s4_valid_ff;
      q_data.kind  = s4_kind_ff;
      q_data.addr1 = CELL_AW_MAX'(s4_addr_ff);
      q_data.addr2 = CELL_AW_MAX'(c2[AW-1:0]);
      q_data.addr3 = CELL_AW_MAX'(c3[AW-1:0]);
      q_data.addr4 = CELL_AW_MAX'(c4[AW-1:0]);
      q_data.dx    = s4_dx_ff;
      q_data.dy    = s4_dy_ff;
      q_data.value = s4_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         used_ff     <= used_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      cells_ff     <= cells_in;

      s1_op_ff     <= req_chan.op;
      s1_neg_x_ff  <= diff_x[32];
      s1_neg_y_ff  <= diff_y[32];
      s1_mag_x_ff  <= mag_x_in;
      s1_mag_y_ff  <= mag_y_in;
      s1_index_ff  <= req_chan.cell_index;
      s1_value_ff  <= req_chan.cell_value;

      s2_op_ff     <= s1_op_ff;
      s2_neg_x_ff  <= s1_neg_x_ff;
      s2_neg_y_ff  <= s1_neg_y_ff;
      s2_prod_x_ff <= prod_x_in;
      s2_prod_y_ff <= prod_y_in;
      s2_index_ff  <= s1_index_ff;
      s2_value_ff  <= s1_value_ff;

      s3_op_ff     <= s2_op_ff;
      s3_jx_ff     <= jx_in;
      s3_jyc_ff    <= jyc_in;
      s3_dx_ff     <= dx_in;
      s3_dy_ff     <= dy_in;
      s3_index_ff  <= s2_index_ff;
      s3_value_ff  <= s2_value_ff;

      s4_kind_ff   <= kind_in;
      s4_addr_ff   <= addr_in;
      s4_dx_ff     <= s3_dx_ff;
      s4_dy_ff     <= s3_dy_ff;
      s4_value_ff  <= s3_value_ff;
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("front: more requests in flight than the queue holds");

endmodule

`default_nettype wire

@@ hw/rtl/rbs_back.sv @@
`default_nettype none

module rbs_back
   import rbs_pkg::*;
#(
   parameter int MAX_CELLS = 65536
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic signed [31:0] floor_value,
   input  wire logic               q_empty,
   input  wire cmd_type            q_data,
   output logic                    q_pop,
   rbs_rsp_if.source               rsp_chan
);

   localparam int AW   = $clog2(MAX_CELLS);
   localparam int RC_W = $clog2(RESULT_DEPTH + 1);
   localparam logic [1:0] LAST_STEP = 2'd3;

   typedef struct packed {
      logic signed [31:0] sample_value;
      logic               outside;
   } rsp_type;

   function automatic logic signed [31:0] sat_floor(input logic signed [50:0] s);
      logic [34:0] q;
      q = s[50:16];
      if (q[34:31] == 4'b0000 || q[34:31] == 4'b1111) begin
         return q[31:0];
      end else if (q[34]) begin
         return 32'h8000_0000;
      end else begin
         return 32'h7FFF_FFFF;
      end
   endfunction

   // read sequencer
   logic               head_valid, is_res, last_step, credit_ok, issue, mem_we;
   logic [1:0]         step_ff, step_in;
   logic [RC_W-1:0]    pend_ff, pend_in;
   logic               rsp_take;
   logic [AW-1:0]      rd_addr;

   logic signed [31:0] store [MAX_CELLS];
   logic signed [31:0] rd_data_ff;

   // read tags, aligned with the read data
   logic               t1_valid_ff, t1_last_ff;
   logic [1:0]         t1_step_ff;
   kind_type           t1_kind_ff;
   logic signed [16:0] t1_dx_ff, t1_dy_ff;
   logic signed [31:0] v1_ff, v2_ff, v3_ff, v1_cur;

   // blend pipeline
   logic signed [17:0] om_x, om_y;
   logic signed [48:0] pa_hi_in, pb_hi_in, pr_hi_in;
   logic signed [49:0] pa_lo_in, pb_lo_in, pr_lo_in;
   logic signed [50:0] sum_a, sum_b, sum_r;

   logic               p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff;
   kind_type           p1_kind_ff, p2_kind_ff, p3_kind_ff, p4_kind_ff;
   logic signed [16:0] p1_dy_ff, p2_dy_ff;
   logic signed [31:0] p1_v1_ff, p2_v1_ff, p3_v1_ff, p4_v1_ff;
   logic signed [48:0] p1_pa_hi_ff, p1_pb_hi_ff, p3_pr_hi_ff;
   logic signed [49:0] p1_pa_lo_ff, p1_pb_lo_ff, p3_pr_lo_ff;
   logic signed [31:0] p2_a_ff, p2_b_ff, p4_r_ff;

   rsp_type            res_din, res_dout;
   logic               res_empty, res_full;

   assign head_valid = !q_empty;
   assign is_res     = q_data.kind inside {KIND_OUTSIDE, KIND_CELL, KIND_BLEND};
   assign last_step  = (q_data.kind != KIND_BLEND) || (step_ff == LAST_STEP);
   assign credit_ok  = (pend_ff < RC_W'(RESULT_DEPTH));
   assign issue      = head_valid && ((step_ff != 2'd0) || !is_res || credit_ok);
   assign q_pop      = issue && last_step;
   assign mem_we     = issue && (q_data.kind == KIND_WRITE);
   assign rsp_take   = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      case (step_ff)
         2'd0:    rd_addr = q_data.addr1[AW-1:0];
         2'd1:    rd_addr = q_data.addr2[AW-1:0];
         2'd2:    rd_addr = q_data.addr3[AW-1:0];
         default: rd_addr = q_data.addr4[AW-1:0];
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (issue) begin
         step_in = last_step ? 2'd0 : step_ff + 1'b1;
      end
      pend_in = pend_ff;
      // reserve a result slot when an item starts, release it when taken
      if (issue && is_res && step_ff == 2'd0 && !rsp_take) begin
         pend_in = pend_ff + 1'b1;
      end else if (!(issue && is_res && step_ff == 2'd0) && rsp_take) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[q_data.addr1[AW-1:0]] <= q_data.value;
      end
      rd_data_ff <= store[rd_addr];
   end

   // gather the neighbours; the last read launches the blend
   assign v1_cur = (t1_step_ff == 2'd0) ? rd_data_ff : v1_ff;

   always_comb begin
      om_x     = 18'(Q_ONE) - 18'(t1_dx_ff);
      pa_hi_in = t1_dx_ff * v2_ff;
      pa_lo_in = om_x * v1_cur;
      pb_hi_in = t1_dx_ff * rd_data_ff;
      pb_lo_in = om_x * v3_ff;
      sum_a    = 51'(p1_pa_hi_ff) + 51'(p1_pa_lo_ff);
      sum_b    = 51'(p1_pb_hi_ff) + 51'(p1_pb_lo_ff);
      om_y     = 18'(Q_ONE) - 18'(p2_dy_ff);
      pr_hi_in = p2_dy_ff * p2_b_ff;
      pr_lo_in = om_y * p2_a_ff;
      sum_r    = 51'(p3_pr_hi_ff) + 51'(p3_pr_lo_ff);
   end

   always_comb begin
      res_din.outside = (p4_kind_ff == KIND_OUTSIDE);
      case (p4_kind_ff)
         KIND_OUTSIDE: res_din.sample_value = floor_value;
         KIND_BLEND:   res_din.sample_value = p4_r_ff;
         default:      res_din.sample_value = p4_v1_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= 2'd0;
         pend_ff     <= '0;
         t1_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
      end else begin
         step_ff     <= step_in;
         pend_ff     <= pend_in;
         t1_valid_ff <= issue && is_res;
         p1_valid_ff <= t1_valid_ff && t1_last_ff;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      t1_last_ff  <= last_step;
      t1_step_ff  <= step_ff;
      t1_kind_ff  <= q_data.kind;
      t1_dx_ff    <= q_data.dx;
      t1_dy_ff    <= q_data.dy;

      if (t1_valid_ff) begin
         case (t1_step_ff)
            2'd0:    v1_ff <= rd_data_ff;
            2'd1:    v2_ff <= rd_data_ff;
            2'd2:    v3_ff <= rd_data_ff;
            default: ;
         endcase
      end

      p1_kind_ff  <= t1_kind_ff;
      p1_dy_ff    <= t1_dy_ff;
      p1_v1_ff    <= v1_cur;
      p1_pa_hi_ff <= pa_hi_in;
      p1_pa_lo_ff <= pa_lo_in;
      p1_pb_hi_ff <= pb_hi_in;
      p1_pb_lo_ff <= pb_lo_in;

      p2_kind_ff  <= p1_kind_ff;
      p2_dy_ff    <= p1_dy_ff;
      p2_v1_ff    <= p1_v1_ff;
      p2_a_ff     <= sat_floor(sum_a);
      p2_b_ff     <= sat_floor(sum_b);

      p3_kind_ff  <= p2_kind_ff;
      p3_v1_ff    <= p2_v1_ff;
      p3_pr_hi_ff <= pr_hi_in;
      p3_pr_lo_ff <= pr_lo_in;

      p4_kind_ff  <= p3_kind_ff;
      p4_v1_ff    <= p3_v1_ff;
      p4_r_ff     <= sat_floor(sum_r);
   end

   rbs_fifo #(
      .DEPTH      (RESULT_DEPTH),
      .entry_type (rsp_type)
   ) u_result_fifo (
      .clock (clock),
      .reset (reset),
      .push  (p4_valid_ff),
      .din   (res_din),
      .pop   (rsp_take),
      .dout  (res_dout),
      .empty (res_empty),
      .full  (res_full)
   );

   assign rsp_chan.valid        = !res_empty;
   assign rsp_chan.sample_value = res_dout.sample_value;
   assign rsp_chan.outside      = res_dout.outside;

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= RC_W'(RESULT_DEPTH))
      else $error("back: result slots over-committed");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      p4_valid_ff |-> !res_full)
      else $error("back: result pushed into a full buffer");

   a_blend_holds: assert property (@(posedge clock) disable iff (reset)
      (step_ff != 2'd0) |-> (head_valid && q_data.kind == KIND_BLEND))
      else $error("back: neighbour reads lost their blend request");

   a_reads_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (t1_valid_ff && !t1_last_ff) |=> t1_valid_ff)
      else $error("back: gap inside a blend read burst");

endmodule

`default_nettype wire

@@ tb/raster_bilinear_sampler_tb.sv @@
`timescale 1ns / 100ps

module raster_bilinear_sampler_tb;
   import rbs_pkg::*;

   localparam int CLOCK_PERIOD    = 20;
   localparam int STORE_CELLS     = 65536;
   localparam int TOTAL_REQUESTS  = 950;
   localparam int SETTLE_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int SMALL_RASTER    = 256;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic signed [31:0] value;
      logic               outside;
   } sample_result_type;

   typedef struct packed {
      logic               op;
      logic signed [31:0] x_pos;
      logic signed [31:0] y_pos;
      logic [15:0]        cell_index;
      logic signed [31:0] cell_value;
   } raster_request_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   rbs_req_if req_chan();
   rbs_rsp_if rsp_chan();

   raster_bilinear_sampler #(
      .MAX_CELLS(STORE_CELLS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   cfg_type            raster_cfg;
   logic signed [31:0] cell_mirror [0:STORE_CELLS-1];
   bit                 cell_known [0:STORE_CELLS-1];
   int                 known_cells[$];
   sample_result_type  pending_samples[$];
   sample_result_type  due;
   int                 failures = 0;
   int                 requests_sent = 0;
   int                 burst_left = 0;
   int                 stall_left = 0;
   bit                 stalling = 1'b0;
   int                 idle_cycles = 0;

   // ---------------------------------------------------------------- predictor

   function automatic longint raster_cells(input cfg_type setting);
      longint cells;
      cells = longint'(setting.columns) * longint'(setting.rows);
      return (cells > STORE_CELLS) ? longint'(STORE_CELLS) : cells;
   endfunction

   // signed offset times unsigned Q16.16 scale, both parts cut toward zero
   function automatic void map_axis(input longint diff, input logic [31:0] scale,
                                    output longint ipart, output longint frac);
      logic [63:0] mag;
      logic [63:0] prod;
      mag   = (diff < 0) ? 64'(-diff) : 64'(diff);
      prod  = mag * {32'd0, scale};
      ipart = longint'({32'd0, prod[63:32]});
      frac  = longint'({48'd0, prod[31:16]});
      if (diff < 0) begin
         ipart = -ipart;
         frac  = -frac;
      end
   endfunction

   function automatic longint mix(input longint w, input longint hi, input longint lo);
      longint acc;
      acc = (w * hi + (Q_ONE - w) * lo) >>> 16;
      if (acc > Q_MAX)
         acc = Q_MAX;
      else if (acc < Q_MIN)
         acc = Q_MIN;
      return acc;
   endfunction

   function automatic longint read_cell(input longint idx, inout bit safe);
      if (!cell_known[idx])
         safe = 1'b0;
      return longint'(cell_mirror[idx]);
   endfunction

   // returns 0 when the sample would touch a cell never written
   function automatic bit predict_sample(input logic signed [31:0] xp, input logic signed [31:0] yp,
                                        output sample_result_type res);
      longint jx, jy, dx, dy, last, j1, j2, j3, j4, v1, v2, v3, v4;
      bit safe;
      safe = 1'b1;
      map_axis(longint'(xp) - longint'($signed(raster_cfg.x_origin)), raster_cfg.x_scale, jx, dx);
      map_axis(longint'($signed(raster_cfg.y_top)) - longint'(yp), raster_cfg.y_scale, jy, dy);
      last = raster_cells(raster_cfg) - 1;
      j1   = jy * longint'(raster_cfg.columns) + jx;
      res.outside = 1'b0;
      if (j1 < 0 || j1 > last) begin
         res.value   = raster_cfg.floor_value;
         res.outside = 1'b1;
         return 1'b1;
      end
      v1 = read_cell(j1, safe);
      if (dx > FRAC_THRESHOLD || dy > FRAC_THRESHOLD) begin
         j2 = j1 + 1;
         j3 = j1 + longint'(raster_cfg.columns);
         j4 = j3 + 1;
         // clamp past the last cell, each onto the one already clamped
         if (j2 > last) j2 = j1;
         if (j3 > last) j3 = j2;
         if (j4 > last) j4 = j3;
         v2 = read_cell(j2, safe);
         v3 = read_cell(j3, safe);
         v4 = read_cell(j4, safe);
         v1 = mix(dy, mix(dx, v4, v3), mix(dx, v2, v1));
      end
      res.value = v1[31:0];
      return safe;
   endfunction

   // -------------------------------------------------------------- stimulus

   function automatic logic signed [31:0] pixel_to_pos(input longint origin,
                                                       input logic [31:0] scale,
                                                       input longint pix_q, input bit downward);
      longint span;
      span = (scale == 0) ? pix_q : (pix_q * Q_ONE) / longint'({32'd0, scale});
      return downward ? 32'(origin - span) : 32'(origin + span);
   endfunction

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 7))
         0:       return Q_MIN;
         1:       return Q_MAX;
         2:       return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   function automatic longint threshold_fraction();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return FRAC_THRESHOLD;
         2:       return FRAC_THRESHOLD + 1;
         default: return Q_ONE - 1;
      endcase
   endfunction

   task automatic send_request(input raster_request_type item);
      sample_result_type res;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid      <= 1'b1;
      req_chan.op         <= item.op;
      req_chan.x_pos      <= item.x_pos;
      req_chan.y_pos      <= item.y_pos;
      req_chan.cell_index <= item.cell_index;
      req_chan.cell_value <= item.cell_value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      requests_sent++;
      if (item.op == OP_WRITE) begin
         cell_mirror[item.cell_index] = item.cell_value;
         if (!cell_known[item.cell_index]) begin
            cell_known[item.cell_index] = 1'b1;
            known_cells.push_back(int'(item.cell_index));
         end
      end else begin
         void'(predict_sample(item.x_pos, item.y_pos, res));
         pending_samples.push_back(res);
      end
   endtask

   task automatic write_cell(input int idx, input logic signed [31:0] value);
      raster_request_type item;
      item.op         = OP_WRITE;
      item.x_pos      = $urandom;
      item.y_pos      = $urandom;
      item.cell_index = idx[15:0];
      item.cell_value = value;
      send_request(item);
   endtask

   task automatic sample_pos(input logic signed [31:0] xp, input logic signed [31:0] yp,
                             output bit sent);
      raster_request_type item;
      sample_result_type res;
      sent = predict_sample(xp, yp, res);
      if (sent) begin
         item.op         = OP_SAMPLE;
         item.x_pos      = xp;
         item.y_pos      = yp;
         item.cell_index = 16'($urandom);
         item.cell_value = $urandom;
         send_request(item);
      end
   endtask

   task automatic sample_pixel(input longint px_q, input longint py_q, output bit sent);
      sample_pos(pixel_to_pos(longint'($signed(raster_cfg.x_origin)), raster_cfg.x_scale, px_q, 1'b0),
                 pixel_to_pos(longint'($signed(raster_cfg.y_top)), raster_cfg.y_scale, py_q, 1'b1),
                 sent);
   endtask

   task automatic hold_requests;
      req_chan.valid <= 1'b0;
   endtask

   // drain every result, then give any write still in flight time to land
   task automatic settle;
      hold_requests;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_config(input cfg_type setting);
      settle;
      write_register(CSR_X_ORIGIN, setting.x_origin);
      write_register(CSR_Y_TOP, setting.y_top);
      write_register(CSR_X_SCALE, setting.x_scale);
      write_register(CSR_Y_SCALE, setting.y_scale);
      write_register(CSR_COLUMNS, {21'd0, setting.columns});
      write_register(CSR_ROWS, {21'd0, setting.rows});
      write_register(CSR_FLOOR_VALUE, setting.floor_value);
      csr_we     <= 1'b0;
      raster_cfg = setting;
   endtask

   // ------------------------------------------------------------------ tests

   task automatic test_cell_reads;
      bit taken;
      apply_config('{x_origin: -32'sh0001_0000, y_top: 32'sh0002_0000, x_scale: Q_ONE,
                     y_scale: Q_ONE, columns: 11'd2, rows: 11'd2, floor_value: Q_MAX});
      write_cell(0, Q_MIN);
      write_cell(1, 32'sh0003_8000);
      write_cell(2, Q_MAX);
      write_cell(3, -32'sh0001_2345);
      sample_pixel(0, 0, taken);
      sample_pixel(Q_ONE, Q_ONE, taken);
      // a fraction of exactly FRAC_THRESHOLD (just under 0.1) still reads the cell alone
      sample_pixel(Q_ONE + FRAC_THRESHOLD, FRAC_THRESHOLD, taken);
   endtask

   task automatic test_blending;
      bit taken;
      sample_pixel(FRAC_THRESHOLD + 1, 0, taken);
      sample_pixel(0, FRAC_THRESHOLD + 1, taken);
      sample_pixel(Q_ONE + Q_ONE / 2, Q_ONE, taken);
      sample_pixel(Q_ONE / 2, Q_ONE + Q_ONE / 2, taken);
      // extrapolate left of the raster, driving both saturation limits
      sample_pixel(-Q_ONE / 2, Q_ONE / 2, taken);
      sample_pixel(-Q_ONE / 2, Q_ONE + Q_ONE / 2, taken);
      sample_pixel(-Q_ONE / 2, -Q_ONE / 2, taken);
   endtask

   task automatic test_outside;
      bit taken;
      sample_pixel(2 * Q_ONE, Q_ONE, taken);
      sample_pixel(0, -Q_ONE - Q_ONE / 2, taken);
      // a column past the row end wraps onto the next row
      sample_pixel(3 * Q_ONE, 0, taken);
      apply_config('{x_origin: 32'sd0, y_top: 32'sd0, x_scale: Q_ONE, y_scale: Q_ONE,
                     columns: 11'd0, rows: 11'd2, floor_value: Q_MIN});
      sample_pixel(0, 0, taken);
      apply_config('{x_origin: 32'sd0, y_top: 32'sd0, x_scale: Q_ONE, y_scale: Q_ONE,
                     columns: 11'd2, rows: 11'd0, floor_value: 32'sh0000_8000});
      sample_pixel(0, 0, taken);
   endtask

   task automatic test_register_extremes;
      bit taken;
      apply_config('{x_origin: Q_MIN, y_top: Q_MAX, x_scale: 32'd0, y_scale: 32'd0,
                     columns: 11'h7FF, rows: 11'h7FF, floor_value: 32'sd0});
      sample_pos(Q_MAX, Q_MIN, taken);
      sample_pos($urandom, $urandom, taken);
      apply_config('{x_origin: Q_MIN, y_top: Q_MAX, x_scale: 32'hFFFF_FFFF,
                     y_scale: 32'hFFFF_FFFF, columns: 11'd1024, rows: 11'd64,
                     floor_value: Q_MAX});
      sample_pos(Q_MIN, Q_MAX, taken);
      sample_pos(Q_MAX, Q_MIN, taken);
      apply_config('{x_origin: Q_MAX, y_top: Q_MIN, x_scale: 32'hFFFF_FFFF,
                     y_scale: 32'hFFFF_FFFF, columns: 11'd1, rows: 11'd1,
                     floor_value: Q_MIN});
      sample_pos(Q_MAX, Q_MIN, taken);
      sample_pos(Q_MIN, Q_MIN, taken);
      apply_config('{x_origin: 32'sd0, y_top: 32'sd0, x_scale: Q_ONE, y_scale: Q_ONE,
                     columns: 11'd1, rows: 11'd1, floor_value: 32'sd0});
      sample_pixel(Q_ONE / 2, Q_ONE / 2, taken);
   endtask

   task automatic random_setting(output cfg_type setting);
      int kind;
      kind = $urandom_range(0, 9);
      setting.floor_value = $urandom;
      if (kind < 7) begin
         setting.x_origin = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
         setting.y_top    = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
         setting.x_scale  = $urandom_range(0, 1) ? Q_ONE : $urandom_range(32'h4000, 32'h4_0000);
         setting.y_scale  = $urandom_range(0, 1) ? Q_ONE : $urandom_range(32'h4000, 32'h4_0000);
         setting.columns  = 11'($urandom_range(1, 20));
         setting.rows     = 11'($urandom_range(1, 12));
      end else begin
         setting.x_origin = $urandom;
         setting.y_top    = $urandom;
         setting.x_scale  = $urandom_range(0, 1) ? Q_ONE : $urandom;
         setting.y_scale  = $urandom_range(0, 1) ? Q_ONE : $urandom;
         setting.columns  = 11'($urandom);
         setting.rows     = 11'($urandom);
         if (kind == 7) begin
            setting.columns = 11'($urandom_range(64, 2047));
            setting.rows    = 11'($urandom_range(32, 2047));
         end else if (kind == 8) begin
            if ($urandom_range(0, 1))
               setting.columns = 11'd0;
            else
               setting.rows = 11'd0;
         end
      end
   endtask

   task automatic random_sample;
      bit taken;
      int tries;
      int mode;
      longint px, py, pick;
      taken = 1'b0;
      tries = 0;
      while (!taken && tries < 8) begin
         tries++;
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            px = longint'($urandom_range(0, (int'(raster_cfg.columns) + 2) * Q_ONE)) - Q_ONE;
            py = longint'($urandom_range(0, (int'(raster_cfg.rows) + 2) * Q_ONE)) - Q_ONE;
            if ($urandom_range(0, 2) == 0)
               px = (px >>> 16) * Q_ONE + threshold_fraction();
            if ($urandom_range(0, 2) == 0)
               py = (py >>> 16) * Q_ONE + threshold_fraction();
            sample_pixel(px, py, taken);
         end else if (mode < 8 && known_cells.size() != 0 && raster_cfg.columns != 0) begin
            pick = known_cells[$urandom_range(0, known_cells.size() - 1)];
            sample_pixel((pick % raster_cfg.columns) * Q_ONE,
                         (pick / raster_cfg.columns) * Q_ONE, taken);
         end else begin
            sample_pos($urandom, $urandom, taken);
         end
      end
   endtask

   task automatic test_random_traffic;
      cfg_type setting;
      longint cells;
      int phases;
      phases = 0;
      while (requests_sent < TOTAL_REQUESTS && phases < 40) begin
         phases++;
         random_setting(setting);
         apply_config(setting);
         cells = raster_cells(setting);
         // fill the whole raster where that is cheap
         if (cells <= SMALL_RASTER) begin
            for (int i = 0; i < cells; i++) begin
               if (!cell_known[i])
                  write_cell(i, random_value());
            end
         end
         repeat ($urandom_range(40, 90)) begin
            if ($urandom_range(0, 6) == 0) begin
               if ($urandom_range(0, 1) && cells != 0)
                  write_cell($urandom_range(0, int'(cells) - 1), random_value());
               else
                  write_cell($urandom_range(0, 16'hFFFF), random_value());
            end else begin
               random_sample;
            end
         end
      end
   endtask

   // ---------------------------------------------------------- result check

   always @(posedge clock) begin
      if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_samples.size() == 0) begin
            $error("unexpected result: sample_value %0d outside %0b",
                   rsp_chan.sample_value, rsp_chan.outside);
            failures++;
         end else begin
            due = pending_samples.pop_front();
            if (rsp_chan.sample_value !== due.value) begin
               $error("sample_value: expected %0d, got %0d", due.value, rsp_chan.sample_value);
               failures++;
            end
            if (rsp_chan.outside !== due.outside) begin
               $error("outside: expected %0b, got %0b", due.outside, rsp_chan.outside);
               failures++;
            end
         end
      end
      // mix long ready stretches with short stalls
      if (stall_left == 0) begin
         stalling   = ($urandom_range(0, 2) == 0);
         stall_left = stalling ? $urandom_range(1, 8) : $urandom_range(1, 40);
      end else begin
         stall_left--;
      end
      rsp_chan.ready <= !stalling;
   end

   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("raster_bilinear_sampler_tb NOT OK");
         $finish;
      end
   end

   initial begin
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= CSR_X_ORIGIN;
      csr_wdata           <= 32'd0;
      req_chan.valid      <= 1'b0;
      req_chan.op         <= OP_WRITE;
      req_chan.x_pos      <= 32'sd0;
      req_chan.y_pos      <= 32'sd0;
      req_chan.cell_index <= 16'd0;
      req_chan.cell_value <= 32'sd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_cell_reads;
      test_blending;
      test_outside;
      test_register_extremes;
      test_random_traffic;

      hold_requests;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("raster_bilinear_sampler_tb OK");
      else
         $display("raster_bilinear_sampler_tb NOT OK");
      $finish;
   end

endmodule
